// File: rtl/lbse_pkg.sv
// Shared types and constants for the label boundary segment extractor.
// No dependencies; used by every other file of the block but lbse_ram.
`default_nettype none

package lbse_pkg;

   localparam int COORD_BITS  = 13;
   localparam int ROW_BITS    = 12;
   localparam int NUM_SIDES   = 4;
   localparam int QUEUE_DEPTH = 4;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [ROW_BITS-1:0]   row_type;
   typedef logic [NUM_SIDES-1:0]  side_mask_type;
   typedef logic [1:0]            csr_index_type;

   typedef enum logic [1:0] {
      SIDE_RIGHT  = 2'd0,
      SIDE_LEFT   = 2'd1,
      SIDE_TOP    = 2'd2,
      SIDE_BOTTOM = 2'd3
   } side_type;

   localparam csr_index_type CSR_FRAME_WIDTH  = 2'd0;
   localparam csr_index_type CSR_FRAME_HEIGHT = 2'd1;

   localparam coord_type FRAME_RESET = 13'd1024;
   localparam coord_type MAX_ROWS    = 13'd4096;

   // one examined pixel: position and the sides that lie on a boundary
   typedef struct packed {
      coord_type     x;
      coord_type     y;
      side_mask_type sides;
   } seg_pos_type;

endpackage

`default_nettype wire

// File: rtl/lbse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lbse_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/lbse_front.sv
// Front end: request intake, raster counters, line buffers and side classification.
// Depends on lbse_pkg and lbse_ram; feeds lbse_queue.
`default_nettype none

module lbse_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int LABEL_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                restart,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      width_in_use,
   input  wire lbse_pkg::coord_type                 height_in_use,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_kind,
   input  wire logic [LABEL_BITS-1:0]               req_label,
   input  wire logic                                q_full,
   output logic                                     push,
   output logic [LABEL_BITS-1:0]                    push_label,
   output lbse_pkg::seg_pos_type                    push_pos
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH+1);

   logic [XW-1:0]     col_ff, col_in;
   lbse_pkg::row_type row_ff, row_in;
   logic              drain_ff, drain_in;

   logic              accept, take, exam, wr_cur, border, last_col, row_last;
   logic [XW-1:0]     cur_rd_addr;
   lbse_pkg::row_type exam_y;

   logic                  b_valid_ff, b_valid_in;
   logic [XW-1:0]         b_col_ff;
   lbse_pkg::row_type     b_y_ff;
   logic                  b_exam_ff, b_wr_cur_ff, b_border_ff, b_first_ff, b_last_ff;
   logic [LABEL_BITS-1:0] b_label_ff;
   logic                  byp_cur_ff, byp_above_ff;
   logic [LABEL_BITS-1:0] byp_cur_data_ff, byp_above_data_ff;
   logic [LABEL_BITS-1:0] cur_next_ff, left_ff;

   logic [LABEL_BITS-1:0]   cur_rd_data, above_rd_data, right_data, top_data, cur;
   lbse_pkg::side_mask_type flags;
   logic                    fire;

   assign accept   = req_valid && req_ready;
   assign last_col = (WW'(col_ff) + WW'(1)) >= width_in_use;
   assign row_last = (lbse_pkg::coord_type'(row_ff) + lbse_pkg::coord_type'(1)) >= height_in_use;
   assign cur_rd_addr = last_col ? '0 : col_ff + XW'(1);
   assign exam_y   = req_kind ? row_ff : row_ff - lbse_pkg::row_type'(1);

   always_comb begin
      take     = 1'b0;
      exam     = 1'b0;
      wr_cur   = 1'b0;
      border   = 1'b0;
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      if (req_kind) begin
         if (drain_ff) begin
            take   = 1'b1;
            exam   = 1'b1;
            border = 1'b1;
         end
      end else if (!drain_ff) begin
         take   = 1'b1;
         exam   = (row_ff != '0);
         wr_cur = 1'b1;
      end
      if (accept && take) begin
         if (last_col) begin
            col_in = '0;
            if (req_kind) begin
               row_in   = '0;
               drain_in = 1'b0;
            end else if (row_last) begin
               drain_in = 1'b1;
            end else begin
               row_in = row_ff + lbse_pkg::row_type'(1);
            end
         end else begin
            col_in = col_ff + XW'(1);
         end
      end
      if (restart) begin
         col_in   = '0;
         row_in   = '0;
         drain_in = 1'b0;
      end
   end

   // row_current holds the newest row, row_above the one before it
   lbse_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_WIDTH)) u_row_current (
      .clock   (clock),
      .wr_en   (fire && b_wr_cur_ff),
      .wr_addr (b_col_ff),
      .wr_data (b_label_ff),
      .rd_en   (accept && take),
      .rd_addr (cur_rd_addr),
      .rd_data (cur_rd_data)
   );

   lbse_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_WIDTH)) u_row_above (
      .clock   (clock),
      .wr_en   (fire && b_exam_ff),
      .wr_addr (b_col_ff),
      .wr_data (cur),
      .rd_en   (accept && take),
      .rd_addr (col_ff),
      .rd_data (above_rd_data)
   );

   assign cur        = cur_next_ff;
   assign right_data = byp_cur_ff   ? byp_cur_data_ff   : cur_rd_data;
   assign top_data   = byp_above_ff ? byp_above_data_ff : above_rd_data;

   always_comb begin
      flags[lbse_pkg::SIDE_RIGHT]  = b_last_ff   || (right_data != cur);
      flags[lbse_pkg::SIDE_LEFT]   = b_first_ff  || (left_ff != cur);
      flags[lbse_pkg::SIDE_TOP]    = (b_y_ff == '0) || (top_data != cur);
      flags[lbse_pkg::SIDE_BOTTOM] = b_border_ff || (b_label_ff != cur);
   end

   assign fire       = b_valid_ff && (!b_exam_ff || !q_full || (flags == '0));
   assign req_ready  = !b_valid_ff || fire;
   assign push       = fire && b_exam_ff && (flags != '0);
   assign push_label = cur;

   always_comb begin
      push_pos.x     = lbse_pkg::coord_type'(b_col_ff);
      push_pos.y     = lbse_pkg::coord_type'(b_y_ff);
      push_pos.sides = flags;
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (accept && take) begin
         b_valid_in = 1'b1;
      end else if (fire) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         drain_ff   <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         drain_ff   <= drain_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && take) begin
         b_col_ff          <= col_ff;
         b_y_ff            <= exam_y;
         b_exam_ff         <= exam;
         b_wr_cur_ff       <= wr_cur;
         b_border_ff       <= border;
         b_first_ff        <= (col_ff == '0);
         b_last_ff         <= last_col;
         b_label_ff        <= req_label;
         byp_cur_ff        <= fire && b_wr_cur_ff && (b_col_ff == cur_rd_addr);
         byp_cur_data_ff   <= b_label_ff;
         byp_above_ff      <= fire && b_exam_ff && (b_col_ff == col_ff);
         byp_above_data_ff <= cur;
      end
      if (fire) begin
         // a one-pixel row: the next pixel sits where this one writes
         cur_next_ff <= (b_wr_cur_ff && b_first_ff && b_last_ff) ? b_label_ff : right_data;
         if (b_exam_ff) begin
            left_ff <= cur;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/lbse_queue.sv
// Short FIFO of classified pixels between front and back ends.
// Depends on lbse_pkg.
`default_nettype none

module lbse_queue #(
   parameter int LABEL_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [LABEL_BITS-1:0] push_label,
   input  wire lbse_pkg::seg_pos_type push_pos,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       empty,
   output logic [LABEL_BITS-1:0]      head_label,
   output lbse_pkg::seg_pos_type      head_pos
);

   localparam int PW = $clog2(lbse_pkg::QUEUE_DEPTH);

   logic [LABEL_BITS-1:0]  label_ff [lbse_pkg::QUEUE_DEPTH];
   lbse_pkg::seg_pos_type  pos_ff   [lbse_pkg::QUEUE_DEPTH];
   logic [PW-1:0]          wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]            count_ff, count_in;

   assign full       = (count_ff == (PW+1)'(lbse_pkg::QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_label = label_ff[rd_ptr_ff];
   assign head_pos   = pos_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         label_ff[wr_ptr_ff] <= push_label;
         pos_ff[wr_ptr_ff]   <= push_pos;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lbse_back.sv
// Back end: expands a queued pixel into segments, one per cycle unless stalled.
// Depends on lbse_pkg; reads the head of lbse_queue and drives the response port.
`default_nettype none

module lbse_back #(
   parameter int LABEL_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  empty,
   input  wire logic [LABEL_BITS-1:0] head_label,
   input  wire lbse_pkg::seg_pos_type head_pos,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [LABEL_BITS-1:0]      rsp_seg_label,
   output lbse_pkg::coord_type        rsp_start_x,
   output lbse_pkg::coord_type        rsp_start_y,
   output lbse_pkg::coord_type        rsp_end_x,
   output lbse_pkg::coord_type        rsp_end_y,
   output logic [1:0]                 rsp_side,
   output logic                       rsp_last
);

   lbse_pkg::side_mask_type done_ff, done_in, remaining, sel_bit;
   lbse_pkg::side_type      sel;
   logic                    is_last, load;
   lbse_pkg::coord_type     x0, y0, x1, y1, sx, sy, ex, ey;

   logic                  rsp_valid_ff;
   logic [LABEL_BITS-1:0] label_ff;
   lbse_pkg::coord_type   sx_ff, sy_ff, ex_ff, ey_ff;
   lbse_pkg::side_type    side_ff;
   logic                  last_ff;

   assign remaining = head_pos.sides & ~done_ff;

   always_comb begin
      if (remaining[lbse_pkg::SIDE_RIGHT]) begin
         sel = lbse_pkg::SIDE_RIGHT;
      end else if (remaining[lbse_pkg::SIDE_LEFT]) begin
         sel = lbse_pkg::SIDE_LEFT;
      end else if (remaining[lbse_pkg::SIDE_TOP]) begin
         sel = lbse_pkg::SIDE_TOP;
      end else begin
         sel = lbse_pkg::SIDE_BOTTOM;
      end
   end

   assign sel_bit = lbse_pkg::side_mask_type'(1) << sel;
   assign is_last = (remaining & ~sel_bit) == '0;
   assign load    = !empty && (!rsp_valid_ff || rsp_ready);
   assign pop     = load && is_last;

   always_comb begin
      done_in = done_ff;
      if (load) begin
         done_in = is_last ? '0 : (done_ff | sel_bit);
      end
   end

   assign x0 = head_pos.x;
   assign y0 = head_pos.y;
   assign x1 = head_pos.x + lbse_pkg::coord_type'(1);
   assign y1 = head_pos.y + lbse_pkg::coord_type'(1);

   always_comb begin
      unique case (sel)
         lbse_pkg::SIDE_RIGHT: begin
            sx = x1; sy = y0; ex = x1; ey = y1;
         end
         lbse_pkg::SIDE_LEFT: begin
            sx = x0; sy = y0; ex = x0; ey = y1;
         end
         lbse_pkg::SIDE_TOP: begin
            sx = x0; sy = y0; ex = x1; ey = y0;
         end
         default: begin
            sx = x0; sy = y1; ex = x1; ey = y1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         done_ff      <= '0;
      end else begin
         done_ff <= done_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         label_ff <= head_label;
         sx_ff    <= sx;
         sy_ff    <= sy;
         ex_ff    <= ex;
         ey_ff    <= ey;
         side_ff  <= sel;
         last_ff  <= is_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_seg_label = label_ff;
   assign rsp_start_x   = sx_ff;
   assign rsp_start_y   = sy_ff;
   assign rsp_end_x     = ex_ff;
   assign rsp_end_y     = ey_ff;
   assign rsp_side      = side_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

// File: rtl/label_boundary_segment_extractor_top.sv
// Top level of the label boundary segment extractor: configuration registers and wiring.
// Depends on lbse_pkg, lbse_front, lbse_queue and lbse_back.
`default_nettype none

// Label pixels enter in raster order on the req_ channel (req_kind 0); each pixel of a row is
// examined when the pixel below it arrives, and the final row is examined by flush requests
// (req_kind 1), one per pixel. Every examined pixel gives between zero and four boundary
// segments (right, left, top, bottom, in that order), with rsp_last set on its final one.
// The front accepts one request per cycle while the four-entry queue has room; the response
// port emits one segment per cycle unless stalled, so an examined pixel holds it for each
// of its segments, if any; the sustained rate is bounded by that port. An examining request
// passes the front's examine stage and the queue before its first segment is registered at
// the port. Two line buffers of MAX_WIDTH labels each hold the previous two rows; neither is
// cleared by reset. A write to frame_width or frame_height restarts the frame at row 0.

module label_boundary_segment_extractor_top #(
   parameter int MAX_WIDTH  = 4096,
   parameter int LABEL_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_kind,
   input  wire logic [LABEL_BITS-1:0]   req_label,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [LABEL_BITS-1:0]        rsp_seg_label,
   output logic [12:0]                  rsp_start_x,
   output logic [12:0]                  rsp_start_y,
   output logic [12:0]                  rsp_end_x,
   output logic [12:0]                  rsp_end_y,
   output logic [1:0]                   rsp_side,
   output logic                         rsp_last,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire lbse_pkg::csr_index_type csr_index,
   input  wire logic [12:0]             csr_data
);

   localparam int WW = $clog2(MAX_WIDTH+1);

   lbse_pkg::coord_type   frame_width_ff, frame_height_ff, height_in_use;
   logic [WW-1:0]         width_in_use;
   logic                  csr_write, restart;

   logic                  q_push, q_full, q_pop, q_empty;
   logic [LABEL_BITS-1:0] q_push_label, q_head_label;
   lbse_pkg::seg_pos_type q_push_pos, q_head_pos;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign restart   = csr_write && ((csr_index == lbse_pkg::CSR_FRAME_WIDTH) ||
                                    (csr_index == lbse_pkg::CSR_FRAME_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= lbse_pkg::FRAME_RESET;
         frame_height_ff <= lbse_pkg::FRAME_RESET;
      end else if (csr_write) begin
         case (csr_index)
            lbse_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            lbse_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         width_in_use = WW'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         width_in_use = WW'(MAX_WIDTH);
      end else begin
         width_in_use = WW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         height_in_use = lbse_pkg::coord_type'(1);
      end else if (frame_height_ff > lbse_pkg::MAX_ROWS) begin
         height_in_use = lbse_pkg::MAX_ROWS;
      end else begin
         height_in_use = frame_height_ff;
      end
   end

   lbse_front #(.MAX_WIDTH(MAX_WIDTH), .LABEL_BITS(LABEL_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .width_in_use  (width_in_use),
      .height_in_use (height_in_use),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_label     (req_label),
      .q_full        (q_full),
      .push          (q_push),
      .push_label    (q_push_label),
      .push_pos      (q_push_pos)
   );

   lbse_queue #(.LABEL_BITS(LABEL_BITS)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_label (q_push_label),
      .push_pos   (q_push_pos),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head_label (q_head_label),
      .head_pos   (q_head_pos)
   );

   lbse_back #(.LABEL_BITS(LABEL_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (q_empty),
      .head_label    (q_head_label),
      .head_pos      (q_head_pos),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_seg_label (rsp_seg_label),
      .rsp_start_x   (rsp_start_x),
      .rsp_start_y   (rsp_start_y),
      .rsp_end_x     (rsp_end_x),
      .rsp_end_y     (rsp_end_y),
      .rsp_side      (rsp_side),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

// File: rtl/lbse_checker.sv
// Port-level checks on the response stream of the segment extractor, plus its bind.
// Depends on lbse_pkg; attaches to label_boundary_segment_extractor_top.
`default_nettype none

module lbse_checker #(
   parameter int LABEL_BITS = 16
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [LABEL_BITS-1:0] rsp_seg_label,
   input wire logic [12:0]           rsp_start_x,
   input wire logic [12:0]           rsp_start_y,
   input wire logic [12:0]           rsp_end_x,
   input wire logic [12:0]           rsp_end_y,
   input wire logic [1:0]            rsp_side,
   input wire logic                  rsp_last
);

   // stalled response holds its label, x coordinates, side and last flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seg_label) &&
         $stable(rsp_start_x) && $stable(rsp_end_x) && $stable(rsp_side) && $stable(rsp_last))
      else $error("response changed while stalled");

   // vertical sides span one row, horizontal sides one column
   a_rsp_geometry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (((rsp_side == lbse_pkg::SIDE_RIGHT) || (rsp_side == lbse_pkg::SIDE_LEFT)) ?
            (rsp_start_x == rsp_end_x) && (rsp_end_y == 13'(rsp_start_y + 13'd1)) :
            (rsp_start_y == rsp_end_y) && (rsp_end_x == 13'(rsp_start_x + 13'd1))))
      else $error("segment end points inconsistent with side");

   // segments of one pixel follow back to back, same label, in rising side order
   a_rsp_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && (rsp_seg_label == $past(rsp_seg_label)) && (rsp_side > $past(rsp_side)))
      else $error("segment group of one pixel broken");

endmodule

bind label_boundary_segment_extractor_top lbse_checker #(.LABEL_BITS(LABEL_BITS))
   u_lbse_checker (.*);

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for label_boundary_segment_extractor_top: label frames in raster
// order, flush requests to drain the final row, and a predicted stream of boundary segments.
// Depends on lbse_pkg and the RTL of the block.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIDTH  = 4096;
   localparam int LABEL_BITS = 16;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // index with no register behind it
   localparam lbse_pkg::csr_index_type CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [15:0]         seg_label;
      lbse_pkg::coord_type start_x;
      lbse_pkg::coord_type start_y;
      lbse_pkg::coord_type end_x;
      lbse_pkg::coord_type end_y;
      lbse_pkg::side_type  side;
      logic                last;
   } segment_type;

   class boundary_predictor;
      logic [15:0]   row_now  [MAX_WIDTH];
      logic [15:0]   row_prev [MAX_WIDTH];
      int unsigned   column;
      int unsigned   row;
      bit            draining;
      int unsigned   width_reg;
      int unsigned   height_reg;
      segment_type   expected_segments [$];
      int            mismatches;

      function new();
         for (int i = 0; i < MAX_WIDTH; i++) begin
            row_now[i]  = '0;
            row_prev[i] = '0;
         end
         column     = 0;
         row        = 0;
         draining   = 1'b0;
         width_reg  = lbse_pkg::FRAME_RESET;
         height_reg = lbse_pkg::FRAME_RESET;
         mismatches = 0;
      endfunction

      function int unsigned width_used();
         int unsigned w;
         w = width_reg;
         if (w < 1) w = 1;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         return w;
      endfunction

      function int unsigned height_used();
         int unsigned h;
         h = height_reg;
         if (h < 1) h = 1;
         if (h > lbse_pkg::MAX_ROWS) h = lbse_pkg::MAX_ROWS;
         return h;
      endfunction

      function segment_type make_segment(logic [15:0] lab, int unsigned sx, int unsigned sy,
                                         int unsigned ex, int unsigned ey,
                                         lbse_pkg::side_type sd);
         segment_type s;
         s.seg_label = lab;
         s.start_x   = lbse_pkg::coord_type'(sx);
         s.start_y   = lbse_pkg::coord_type'(sy);
         s.end_x     = lbse_pkg::coord_type'(ex);
         s.end_y     = lbse_pkg::coord_type'(ey);
         s.side      = sd;
         s.last      = 1'b0;
         return s;
      endfunction

      function void examine(int unsigned x, int unsigned y, bit below_border,
                            logic [15:0] below);
         int unsigned w;
         logic [15:0] cur;
         segment_type found [$];
         w   = width_used();
         cur = row_now[x];
         if (x + 1 >= w || row_now[x + 1] != cur)
            found = {found, make_segment(cur, x + 1, y, x + 1, y + 1, lbse_pkg::SIDE_RIGHT)};
         if (x == 0 || row_prev[x - 1] != cur)
            found = {found, make_segment(cur, x, y, x, y + 1, lbse_pkg::SIDE_LEFT)};
         if (y == 0 || row_prev[x] != cur)
            found = {found, make_segment(cur, x, y, x + 1, y, lbse_pkg::SIDE_TOP)};
         if (below_border || below != cur)
            found = {found, make_segment(cur, x, y + 1, x + 1, y + 1, lbse_pkg::SIDE_BOTTOM)};
         row_prev[x] = cur;
         if (found.size() > 0) found[found.size() - 1].last = 1'b1;
         foreach (found[i]) expected_segments = {expected_segments, found[i]};
      endfunction

      function void write_register(lbse_pkg::csr_index_type index, logic [12:0] value);
         if (index == lbse_pkg::CSR_FRAME_WIDTH) width_reg = value;
         else if (index == lbse_pkg::CSR_FRAME_HEIGHT) height_reg = value;
         else return;
         column   = 0;
         row      = 0;
         draining = 1'b0;
      endfunction

      function void note_request(logic kind, logic [15:0] lab);
         int unsigned w;
         int unsigned h;
         int unsigned x;
         w = width_used();
         h = height_used();
         x = column;
         if (x >= w) x = w - 1;
         if (kind == REQ_FLUSH) begin
            if (!draining) return;
            examine(x, row, 1'b1, '0);
            column = x + 1;
            if (column >= w) begin
               column   = 0;
               row      = 0;
               draining = 1'b0;
            end
            return;
         end
         if (draining) return;
         if (row > 0) examine(x, row - 1, 1'b0, lab);
         row_now[x] = lab;
         column = x + 1;
         if (column >= w) begin
            column = 0;
            if (row + 1 >= h) draining = 1'b1;
            else row = row + 1;
         end
      endfunction

      function void check_segment(segment_type got);
         segment_type want;
         if (expected_segments.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected segment: label %h (%0d,%0d)-(%0d,%0d) side %0d last %b",
                        got.seg_label, got.start_x, got.start_y, got.end_x, got.end_y,
                        got.side, got.last);
            return;
         end
         want = expected_segments.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("segment mismatch, expected label %h (%0d,%0d)-(%0d,%0d) side %0d last %b",
                        want.seg_label, want.start_x, want.start_y, want.end_x, want.end_y,
                        want.side, want.last);
               $display("                    actual label %h (%0d,%0d)-(%0d,%0d) side %0d last %b",
                        got.seg_label, got.start_x, got.start_y, got.end_x, got.end_y,
                        got.side, got.last);
            end
         end
      endfunction

      function int outstanding();
         return expected_segments.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_kind = REQ_PIXEL;
   logic [LABEL_BITS-1:0]   req_label = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [LABEL_BITS-1:0]   rsp_seg_label;
   logic [12:0]             rsp_start_x;
   logic [12:0]             rsp_start_y;
   logic [12:0]             rsp_end_x;
   logic [12:0]             rsp_end_y;
   logic [1:0]              rsp_side;
   logic                    rsp_last;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   lbse_pkg::csr_index_type csr_index = lbse_pkg::CSR_FRAME_WIDTH;
   logic [12:0]             csr_data = '0;

   boundary_predictor sb = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off      = 1'b0;
   bit pressure_go   = 1'b0;
   int random_items  = 0;

   label_boundary_segment_extractor_top #(
      .MAX_WIDTH  (MAX_WIDTH),
      .LABEL_BITS (LABEL_BITS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_label     (req_label),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_seg_label (rsp_seg_label),
      .rsp_start_x   (rsp_start_x),
      .rsp_start_y   (rsp_start_y),
      .rsp_end_x     (rsp_end_x),
      .rsp_end_y     (rsp_end_y),
      .rsp_side      (rsp_side),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      segment_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.seg_label = rsp_seg_label;
         got.start_x   = rsp_start_x;
         got.start_y   = rsp_start_y;
         got.end_x     = rsp_end_x;
         got.end_y     = rsp_end_y;
         got.side      = lbse_pkg::side_type'(rsp_side);
         got.last      = rsp_last;
         sb.check_segment(got);
      end
   end

   // long receiver stall so the queue fills and the request side backs up
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (80) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      #400000;
      $display("label_boundary_segment_extractor_top: mismatch");
      $finish;
   end

   task automatic send_request(input logic kind, input logic [15:0] lab);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 4);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind  = kind;
      req_label = lab;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, lab);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_csr(input lbse_pkg::csr_index_type index, input logic [12:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(index, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // wait for every segment, then allow for pixels still in flight that give none
   task automatic settle();
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic run_frame(input int w, input int h, input bit abort);
      logic [15:0] palette [3];
      int total;
      int stop_at;
      int k;
      for (int i = 0; i < 3; i++) palette[i] = 16'($urandom_range(65535));
      total   = w * (h + 1);
      stop_at = abort ? $urandom_range(total - 1) : total;
      k       = 0;
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            if (k == stop_at) return;
            if ($urandom_range(99) < 3) send_request(REQ_FLUSH, 16'($urandom_range(65535)));
            send_request(REQ_PIXEL, ($urandom_range(99) < 85) ? palette[$urandom_range(2)]
                                                             : 16'($urandom_range(65535)));
            k++;
            random_items++;
         end
      end
      for (int c = 0; c < w; c++) begin
         if (k == stop_at) return;
         if ($urandom_range(99) < 5) send_request(REQ_PIXEL, 16'($urandom_range(65535)));
         send_request(REQ_FLUSH, 16'($urandom_range(65535)));
         k++;
         random_items++;
      end
   endtask

   initial begin
      int cur_w;
      int cur_h;
      int pick;
      bit first_frame;
      bit pressure_frame;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (2) @(negedge clock);

      // reset geometry: first row only stores, flush outside drain is dropped
      send_request(REQ_PIXEL, 16'h0000);
      send_request(REQ_PIXEL, 16'hFFFF);
      send_request(REQ_PIXEL, 16'hA5A5);
      send_request(REQ_FLUSH, 16'hFFFF);
      settle();
      write_csr(CSR_SPARE, 13'h1FFF);
      send_request(REQ_PIXEL, 16'h5A5A);
      settle();

      // 2x2 frame, pixel during drain, flush after drain
      write_csr(lbse_pkg::CSR_FRAME_WIDTH, 13'd2);
      write_csr(lbse_pkg::CSR_FRAME_HEIGHT, 13'd2);
      send_request(REQ_PIXEL, 16'h0000);
      send_request(REQ_PIXEL, 16'hFFFF);
      send_request(REQ_PIXEL, 16'hFFFF);
      send_request(REQ_PIXEL, 16'hFFFF);
      send_request(REQ_PIXEL, 16'h1234);
      send_request(REQ_FLUSH, 16'h0000);
      send_request(REQ_FLUSH, 16'hFFFF);
      send_request(REQ_FLUSH, 16'h0000);
      settle();

      // zero registers clamp to a 1x1 frame
      write_csr(lbse_pkg::CSR_FRAME_WIDTH, 13'd0);
      write_csr(lbse_pkg::CSR_FRAME_HEIGHT, 13'd0);
      send_request(REQ_PIXEL, 16'h8001);
      send_request(REQ_FLUSH, 16'h7FFE);
      settle();

      // oversized and maximum geometry, left partial and restarted
      write_csr(lbse_pkg::CSR_FRAME_WIDTH, 13'h1FFF);
      write_csr(lbse_pkg::CSR_FRAME_HEIGHT, 13'h1FFF);
      send_request(REQ_PIXEL, 16'hFFFF);
      send_request(REQ_PIXEL, 16'h0001);
      settle();
      write_csr(lbse_pkg::CSR_FRAME_WIDTH, 13'd4096);
      write_csr(lbse_pkg::CSR_FRAME_HEIGHT, 13'd4096);
      send_request(REQ_PIXEL, 16'h0002);
      send_request(REQ_PIXEL, 16'hFFFE);
      settle();

      cur_w = 4096;
      cur_h = 4096;
      first_frame = 1'b1;
      pressure_frame = 1'b0;
      while (random_items < 270) begin
         if (random_items < 90) begin
            send_idle_pct = 26;
            recv_idle_pct = 55;
         end else if (random_items < 180) begin
            send_idle_pct = 55;
            recv_idle_pct = 26;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         settle();
         pick = $urandom_range(3);
         if (random_items >= 180 && !pressure_go) begin
            cur_w = 6;
            cur_h = 4;
            pressure_frame = 1'b1;
            pick = 1;
         end else if ($urandom_range(99) < 80) begin
            cur_w = $urandom_range(1, 8);
            cur_h = $urandom_range(1, 6);
         end else begin
            cur_w = $urandom_range(9, 24);
            cur_h = $urandom_range(1, 2);
         end
         if (first_frame || pressure_frame || pick != 0) begin
            if ($urandom_range(1)) begin
               write_csr(lbse_pkg::CSR_FRAME_WIDTH, 13'(cur_w));
               write_csr(lbse_pkg::CSR_FRAME_HEIGHT, 13'(cur_h));
            end else begin
               write_csr(lbse_pkg::CSR_FRAME_HEIGHT, 13'(cur_h));
               write_csr(lbse_pkg::CSR_FRAME_WIDTH, 13'(cur_w));
            end
         end else if ($urandom_range(1)) begin
            write_csr(lbse_pkg::CSR_FRAME_WIDTH, 13'(cur_w));
            cur_h = sb.height_used();
         end else begin
            write_csr(lbse_pkg::CSR_FRAME_HEIGHT, 13'(cur_h));
            cur_w = sb.width_used();
         end
         first_frame = 1'b0;
         if (pressure_frame) pressure_go = 1'b1;
         run_frame(cur_w, cur_h, !pressure_frame && ($urandom_range(99) < 8));
         pressure_frame = 1'b0;
      end

      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("label_boundary_segment_extractor_top: match");
      end else begin
         $display("label_boundary_segment_extractor_top: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
